FILE: hw/rtl/bffs_pkg.sv
// Shared types and constants for the box filter frequency split core.
package bffs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int HIST_DEPTH  = 32;
    localparam int HIST_AW     = 5;
    localparam int CFG_W       = 11;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;

    localparam logic [10:0] RESET_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RESET_FRAME_HEIGHT = 11'd480;
    localparam logic [3:0]  RESET_RADIUS       = 4'd1;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS       = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic {
        KIND_PIXEL,
        KIND_DRAIN
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] pixel;
    } entry_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [3:0]  radius;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

FILE: hw/rtl/box_filter_frequency_split_core.sv
// Top level: box mean filter splitting a pixel plane into low and high parts.
// An item goes through the back end as queue pop and update, plus an output load for a result;
// an interior pixel also waits for the bit-serial divider before its result is loaded.
// A result leaves radius*width + radius pixel items after its own pixel; drains flush the tail.
// A 4-entry queue decouples input acceptance from the back end.
// Synchronous active-low reset clears counters, queue, sums and config (640x480, radius 1);
// the line store and column sums are not cleared.
module box_filter_frequency_split_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [bffs_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bffs_pkg::TDATA_IN_W-1:0]   s_tdata,   // pixel
    input  logic                              s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bffs_pkg::TDATA_OUT_W-1:0]  m_tdata,   // low_part, high_part, zero fill
    output logic                              m_tlast    // frame_end
);

    localparam int DEN_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int NUM_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1) + 1;

    bffs_pkg::cfg_t   cfg_reg, cfg_next;
    bffs_pkg::entry_t q_entry;
    logic             q_valid;
    logic             q_pop;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                bffs_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_wdata;
                bffs_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_wdata;
                bffs_pkg::REG_RADIUS:       cfg_next.radius       = cfg_wdata[3:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= bffs_pkg::RESET_FRAME_WIDTH;
            cfg_reg.frame_height <= bffs_pkg::RESET_FRAME_HEIGHT;
            cfg_reg.radius       <= bffs_pkg::RESET_RADIUS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bffs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_entry  (q_entry),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    bffs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    bffs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS),
        .NUM_W      (NUM_W),
        .DEN_W      (DEN_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_entry   (q_entry),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_done  (div_done),
        .div_quo   (div_quo),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_busy)
        else $error("divider did not start");

    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> q_valid)
        else $error("accepted item missing from queue");

endmodule

FILE: hw/rtl/bffs_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
module bffs_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // pixel
    input  logic                   s_tuser,   // command
    output bffs_pkg::entry_t       q_entry,
    output logic                   q_valid,
    input  logic                   q_pop
);

    bffs_pkg::entry_t                 mem_reg [bffs_pkg::QUEUE_DEPTH];
    logic [bffs_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bffs_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bffs_pkg::QUEUE_AW:0]      count_reg, count_next;
    bffs_pkg::entry_t                 new_entry;
    logic                             push;
    logic                             pop;

    assign s_tready = (count_reg != (bffs_pkg::QUEUE_AW+1)'(bffs_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        new_entry.pixel = s_tdata;
        new_entry.kind  = (s_tuser == bffs_pkg::CMD_DRAIN) ? bffs_pkg::KIND_DRAIN
                                                            : bffs_pkg::KIND_PIXEL;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/bffs_div.sv
// Restoring divider, one quotient bit per cycle.
module bffs_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: hw/rtl/bffs_back.sv
// Back end: line store, running box sums, position tracking and output register.
module bffs_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 15,
    parameter int NUM_W      = 19,
    parameter int DEN_W      = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bffs_pkg::cfg_t                      cfg,
    input  bffs_pkg::entry_t                    q_entry,
    input  logic                                q_valid,
    output logic                                q_pop,
    output logic                                div_start,
    output logic [NUM_W-1:0]                    div_num,
    output logic [DEN_W-1:0]                    div_den,
    input  logic                                div_done,
    input  logic [NUM_W-1:0]                    div_quo,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bffs_pkg::TDATA_OUT_W-1:0]    m_tdata,   // low_part, high_part, zero fill
    output logic                                m_tlast    // frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RDW   = $clog2(MAX_RADIUS + 1);
    localparam int SLOTS = 2 * MAX_RADIUS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int CSW   = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int WSW   = NUM_W - 1;
    localparam int LSD   = SLOTS * (2 ** CW);
    localparam int HAW   = bffs_pkg::HIST_AW;

    bffs_pkg::back_state_t state_reg, state_next;

    logic [7:0]     line_store [LSD];
    logic [CSW-1:0] column_sums [MAX_WIDTH];
    logic [CSW-1:0] hist_reg [bffs_pkg::HIST_DEPTH];

    logic [7:0]     rd_out_reg;
    logic [7:0]     rd_in_reg;
    logic [CSW-1:0] rd_cs_reg;

    bffs_pkg::entry_t entry_reg, entry_next;

    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [SW-1:0]  in_slot_reg, in_slot_next;
    logic [SW-1:0]  out_slot_reg, out_slot_next;
    logic [PW-1:0]  pending_reg, pending_next;
    logic [WSW-1:0] ws_reg, ws_next;

    logic [7:0]     src_reg, src_next;
    logic           interior_reg, interior_next;
    logic           fend_reg, fend_next;

    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_low_reg, m_low_next;
    logic [8:0]     m_high_reg, m_high_next;
    logic           m_last_reg, m_last_next;

    logic [WW-1:0]  eff_w;
    logic [HW-1:0]  eff_h;
    logic [RDW-1:0] eff_r;
    logic [RDW:0]   side;
    logic [SW:0]    slot_n;
    logic [PW-1:0]  lag;
    logic [DEN_W-1:0] side_p1;
    logic [DEN_W-1:0] area;

    logic           is_pixel;
    logic           drain_ok;
    logic           emit_c;
    logic           interior_c;
    logic           fend_c;
    logic           out_free;
    logic [CSW-1:0] prev_c;
    logic [CSW-1:0] v_c;
    logic [CSW-1:0] cs_wr_c;
    logic [WSW-1:0] ws_c;
    logic [HAW-1:0] hidx_old;
    logic [HAW-1:0] hidx_new;
    logic           write_pix;
    logic           write_sums;
    logic [SW+CW-1:0] in_addr;
    logic [SW+CW-1:0] out_addr;
    logic [7:0]     lo_c;

    // effective geometry
    always_comb begin
        if (cfg.frame_width == '0) begin
            eff_w = WW'(1);
        end else if (cfg.frame_width > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg.frame_width);
        end
        if (cfg.frame_height == '0) begin
            eff_h = HW'(1);
        end else if (cfg.frame_height > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(cfg.frame_height);
        end
        eff_r   = (cfg.radius > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(cfg.radius);
        side    = {eff_r, 1'b0};
        slot_n  = (eff_r != '0) ? (SW+1)'(side) : (SW+1)'(1);
        lag     = PW'(eff_r) * PW'(eff_w) + PW'(eff_r);
        side_p1 = DEN_W'(side) + 1'b1;
        area    = side_p1 * side_p1;
    end

    assign in_addr  = {in_slot_reg, in_col_reg};
    assign out_addr = {out_slot_reg, out_col_reg};
    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = (state_reg == bffs_pkg::ST_IDLE) && q_valid;

    // decode of the item in flight
    always_comb begin
        is_pixel = (entry_reg.kind == bffs_pkg::KIND_PIXEL);
        drain_ok = (in_row_reg == '0) && (in_col_reg == '0) && (pending_reg != '0);
        emit_c   = (pending_reg >= lag);
        fend_c   = ((out_row_reg + 1) >= eff_h) && ((out_col_reg + 1) >= eff_w);
        prev_c   = (in_row_reg == '0) ? '0 : rd_cs_reg;
        v_c      = prev_c + CSW'(entry_reg.pixel);
        cs_wr_c  = (in_row_reg >= side) ? v_c - CSW'(rd_in_reg) : v_c;
        hidx_old = HAW'(in_col_reg - side - 1);
        hidx_new = HAW'(in_col_reg);
        ws_c     = ((in_col_reg == '0) ? '0 : ws_reg) + WSW'(v_c);
        if (in_col_reg >= side + 1) begin
            ws_c = ws_c - WSW'(hist_reg[hidx_old]);
        end
        interior_c = (eff_r != '0) && (in_row_reg >= side) && (in_col_reg >= side)
                     && (pending_reg != '0)
                     && ((RW+5)'(out_row_reg) + (RW+5)'(eff_r) == (RW+5)'(in_row_reg))
                     && ((CW+5)'(out_col_reg) + (CW+5)'(eff_r) == (CW+5)'(in_col_reg));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bffs_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = bffs_pkg::ST_CALC;
                end
            end
            bffs_pkg::ST_CALC: begin
                if (is_pixel) begin
                    if (emit_c && interior_c) begin
                        state_next = bffs_pkg::ST_DIV;
                    end else if (emit_c) begin
                        state_next = bffs_pkg::ST_EMIT;
                    end else begin
                        state_next = bffs_pkg::ST_IDLE;
                    end
                end else if (drain_ok) begin
                    state_next = bffs_pkg::ST_EMIT;
                end else begin
                    state_next = bffs_pkg::ST_IDLE;
                end
            end
            bffs_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = bffs_pkg::ST_EMIT;
                end
            end
            bffs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = bffs_pkg::ST_IDLE;
                end
            end
            default: state_next = bffs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        entry_next    = entry_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        in_slot_next  = in_slot_reg;
        out_slot_next = out_slot_reg;
        pending_next  = pending_reg;
        ws_next       = ws_reg;
        src_next      = src_reg;
        interior_next = interior_reg;
        fend_next     = fend_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_low_next    = m_low_reg;
        m_high_next   = m_high_reg;
        m_last_next   = m_last_reg;
        write_pix     = 1'b0;
        write_sums    = 1'b0;
        div_start     = 1'b0;
        div_num       = NUM_W'(ws_c) + NUM_W'(area >> 1);
        div_den       = area;
        lo_c          = interior_reg ? div_quo[7:0] : src_reg;

        case (state_reg)
            bffs_pkg::ST_IDLE: begin
                if (q_valid) begin
                    entry_next = q_entry;
                end
            end
            bffs_pkg::ST_CALC: begin
                fend_next = fend_c;
                if (is_pixel) begin
                    write_pix     = 1'b1;
                    src_next      = (pending_reg == '0) ? entry_reg.pixel : rd_out_reg;
                    interior_next = interior_c;
                    if (eff_r != '0) begin
                        write_sums = 1'b1;
                        ws_next    = ws_c;
                    end
                    if (emit_c) begin
                        div_start = interior_c;
                    end else begin
                        pending_next = pending_reg + 1'b1;
                    end
                    if ((in_col_reg + 1) >= eff_w) begin
                        in_col_next  = '0;
                        in_row_next  = ((in_row_reg + 1) >= eff_h) ? '0 : in_row_reg + 1'b1;
                        in_slot_next = (((SW+1)'(in_slot_reg) + 1'b1) >= slot_n)
                                       ? '0 : in_slot_reg + 1'b1;
                    end else begin
                        in_col_next = in_col_reg + 1'b1;
                    end
                end else begin
                    src_next      = rd_out_reg;
                    interior_next = 1'b0;
                    if (drain_ok) begin
                        pending_next = pending_reg - 1'b1;
                    end
                end
                if ((is_pixel && emit_c) || (!is_pixel && drain_ok)) begin
                    if ((out_col_reg + 1) >= eff_w) begin
                        out_col_next  = '0;
                        out_row_next  = ((out_row_reg + 1) >= eff_h) ? '0 : out_row_reg + 1'b1;
                        out_slot_next = (((SW+1)'(out_slot_reg) + 1'b1) >= slot_n)
                                        ? '0 : out_slot_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
            bffs_pkg::ST_DIV: begin
            end
            bffs_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_low_next   = lo_c;
                    m_high_next  = interior_reg ? 9'({1'b0, src_reg} - {1'b0, lo_c}) : '0;
                    m_last_next  = fend_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bffs_pkg::TDATA_OUT_W'({m_high_reg, m_low_reg});
    assign m_tlast  = m_last_reg;

    // line store: two read ports, one write port
    always_ff @(posedge aclk) begin
        if (write_pix) begin
            line_store[in_addr] <= entry_reg.pixel;
        end
        rd_out_reg <= line_store[out_addr];
        rd_in_reg  <= line_store[in_addr];
    end

    always_ff @(posedge aclk) begin
        if (write_sums) begin
            column_sums[in_col_reg] <= cs_wr_c;
        end
        rd_cs_reg <= column_sums[in_col_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bffs_pkg::HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (write_sums) begin
            hist_reg[hidx_new] <= v_c;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg    <= entry_next;
        src_reg      <= src_next;
        interior_reg <= interior_next;
        fend_reg     <= fend_next;
        m_low_reg    <= m_low_next;
        m_high_reg   <= m_high_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bffs_pkg::ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            in_slot_reg  <= '0;
            out_slot_reg <= '0;
            pending_reg  <= '0;
            ws_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            in_slot_reg  <= in_slot_next;
            out_slot_reg <= out_slot_next;
            pending_reg  <= pending_next;
            ws_reg       <= ws_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule
